FILE: src/stli_pkg.sv
// ----------------------------------------------------------------------------
// stli_pkg: shared types for the sorted table linear interpolator
// Operation and status codes, widths and the links between table cells.
// ----------------------------------------------------------------------------
package stli_pkg;

    localparam int TableDepthDefault = 64;
    localparam int AngleW = 16;
    localparam int LiftW  = 16;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Travels from a cell to its right neighbor (higher index).
    typedef struct packed {
        logic                     valid;
        logic                     gt;
        logic                     below;
        logic signed [AngleW-1:0] angle;
        logic signed [LiftW-1:0]  lift;
    } t_fwd;

    // Travels from a cell to its left neighbor (lower index).
    typedef struct packed {
        logic valid;
        logic below;
        logic eq;
    } t_bwd;

    // Per-cell flags seen by the query logic.
    typedef struct packed {
        logic                     lo_hit;
        logic                     hi_hit;
        logic                     ex_hit;
        logic                     max_hit;
        logic signed [AngleW-1:0] angle;
        logic signed [LiftW-1:0]  lift;
    } t_tap;

endpackage

FILE: src/stli_if.sv
// ----------------------------------------------------------------------------
// stli_in_if / stli_out_if: request and result channels
// Valid/ready channels carrying one request or one result.
// ----------------------------------------------------------------------------
interface stli_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [15:0] angle_in;
    logic signed [15:0] lift_in;
    modport source (output valid, operation, angle_in, lift_in, input ready);
    modport sink   (input valid, operation, angle_in, lift_in, output ready);
endinterface

interface stli_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [15:0] lift_out;
    modport source (output valid, status, lift_out, input ready);
    modport sink   (input valid, status, lift_out, output ready);
endinterface

FILE: src/sorted_table_linear_interpolator.sv
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator: sorted (angle, lift) table with lookup
// Appends pairs in sorted order and answers queries by linear interpolation.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on i_in (operation, angle_in, lift_in) and each gives
// exactly one result on o_out (status, lift_out). A request is taken only
// when the block is idle, one at a time.
// Clear, append, unused codes and a query on an empty table go from S_IDLE
// straight to S_FIN, where the result register is loaded for the handoff.
// A query outside the table range passes through S_SEL first.
// An interpolating query picks the segment from the cell row (S_SEL),
// multiplies (S_MUL), forms the magnitude (S_ABS), loads the serial divider
// and runs it (S_DIV), adds and saturates as the divider finishes, and
// loads the result register for the handoff (S_FIN).
// The serial divider sets the query rate.
// The table is a row of TABLE_DEPTH cells; an append shifts the larger
// entries one cell right together.
// Reset empties the table and drops any pending result. If the receiver
// stalls, the result register holds its value; the next result waits in S_FIN.
// ----------------------------------------------------------------------------
module sorted_table_linear_interpolator
    import stli_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepthDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stli_in_if.sink    i_in,
    stli_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE, S_SEL, S_MUL, S_ABS, S_DIV, S_FIN
    } t_state;

    t_state                   r_state;
    logic signed [AngleW-1:0] r_q;
    logic signed [AngleW-1:0] r_a0, r_a1;
    logic signed [LiftW-1:0]  r_l0, r_l1;
    logic signed [33:0]       r_prod;
    logic [16:0]              r_den;
    logic                     r_neg;
    logic [1:0]               r_res_status;
    logic signed [LiftW-1:0]  r_res_lift;
    logic                     r_out_valid;
    logic [1:0]               r_out_status;
    logic signed [LiftW-1:0]  r_out_lift;
    logic                     r_div_start;
    logic [31:0]              r_div_dvd;

    t_fwd                     w_fwd [TABLE_DEPTH+1];
    t_bwd                     w_bwd [TABLE_DEPTH+1];
    t_tap                     w_tap [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]   w_lo_vec;
    logic signed [AngleW-1:0] w_key;
    logic                     w_accept;
    logic                     w_clear;
    logic                     w_insert;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_any_lo, w_any_hi, w_any_max;
    logic signed [AngleW-1:0] w_lo_angle, w_hi_angle;
    logic signed [LiftW-1:0]  w_lo_lift, w_hi_lift, w_ex_lift;
    logic                     w_below_min;
    logic signed [16:0]       w_dq, w_dl;
    logic                     w_div_done;
    logic [31:0]              w_div_quo;
    logic signed [33:0]       w_quo;
    logic signed [33:0]       w_sum;
    logic signed [LiftW-1:0]  w_sat;
    logic                     w_out_free;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_clear    = w_accept && (t_op'(i_in.operation) == OP_CLEAR);
    assign w_full     = w_fwd[TABLE_DEPTH].valid;
    assign w_empty    = !w_fwd[1].valid;
    assign w_insert   = w_accept && (t_op'(i_in.operation) == OP_APPEND) && !w_full;
    assign w_key      = (r_state == S_IDLE) ? i_in.angle_in : r_q;
    assign w_out_free = !r_out_valid || o_out.ready;

    // Boundaries of the cell row.
    assign w_fwd[0] = '{valid: 1'b1, gt: 1'b0, below: 1'b0, angle: '0, lift: '0};
    assign w_bwd[TABLE_DEPTH] = '{valid: 1'b0, below: 1'b0, eq: 1'b0};

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        stli_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (w_clear),
            .i_insert(w_insert),
            .i_key   (w_key),
            .i_lift  (i_in.lift_in),
            .i_left  (w_fwd[g]),
            .i_right (w_bwd[g+1]),
            .o_fwd   (w_fwd[g+1]),
            .o_bwd   (w_bwd[g]),
            .o_tap   (w_tap[g])
        );
        assign w_lo_vec[g] = w_tap[g].lo_hit;
    end

    // At most one cell raises each flag, so the selection is a plain OR.
    always_comb begin
        w_any_lo   = 1'b0;
        w_any_hi   = 1'b0;
        w_any_max  = 1'b0;
        w_lo_angle = '0;
        w_lo_lift  = '0;
        w_hi_angle = '0;
        w_hi_lift  = '0;
        w_ex_lift  = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            w_any_lo  = w_any_lo | w_tap[k].lo_hit;
            w_any_hi  = w_any_hi | w_tap[k].hi_hit;
            w_any_max = w_any_max | w_tap[k].max_hit;
            w_lo_angle = w_lo_angle | (w_tap[k].lo_hit ? w_tap[k].angle : '0);
            w_lo_lift  = w_lo_lift  | (w_tap[k].lo_hit ? w_tap[k].lift  : '0);
            w_hi_angle = w_hi_angle | (w_tap[k].hi_hit ? w_tap[k].angle : '0);
            w_hi_lift  = w_hi_lift  | (w_tap[k].hi_hit ? w_tap[k].lift  : '0);
            w_ex_lift  = w_ex_lift  | (w_tap[k].ex_hit ? w_tap[k].lift  : '0);
        end
    end

    assign w_below_min = !w_bwd[0].below && !w_bwd[0].eq;

    assign w_dq = {r_q[15], r_q} - {r_a0[15], r_a0};
    assign w_dl = {r_l1[15], r_l1} - {r_l0[15], r_l0};

    stli_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_start),
        .i_dividend(r_div_dvd),
        .i_divisor (r_den),
        .o_done    (w_div_done),
        .o_quotient(w_div_quo)
    );

    assign w_quo = r_neg ? -$signed({2'b00, w_div_quo}) : $signed({2'b00, w_div_quo});
    assign w_sum = {{18{r_l0[15]}}, r_l0} + w_quo;

    always_comb begin
        if (w_sum > 34'sd32767) begin
            w_sat = 16'sh7FFF;
        end else if (w_sum < -34'sd32768) begin
            w_sat = 16'sh8000;
        end else begin
            w_sat = w_sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= (r_state == S_ABS);
            if (r_out_valid && o_out.ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_lift <= '0;
                        r_q        <= i_in.angle_in;
                        unique case (t_op'(i_in.operation))
                            OP_APPEND: begin
                                r_res_status <= w_full ? ST_FULL : ST_OK;
                                r_state      <= S_FIN;
                            end
                            OP_QUERY: begin
                                r_res_status <= w_empty ? ST_EMPTY : ST_OK;
                                r_state      <= w_empty ? S_FIN : S_SEL;
                            end
                            OP_CLEAR, OP_NONE: begin
                                r_res_status <= ST_OK;
                                r_state      <= S_FIN;
                            end
                        endcase
                    end
                end
                S_SEL: begin
                    r_a0 <= w_lo_angle;
                    r_l0 <= w_lo_lift;
                    r_a1 <= w_hi_angle;
                    r_l1 <= w_hi_lift;
                    priority if (w_below_min || w_any_max) begin
                        r_res_status <= ST_RANGE;
                        r_state      <= S_FIN;
                    end else if (!w_any_lo) begin
                        // The query sits on the minimum: take the last equal entry.
                        r_res_lift <= w_ex_lift;
                        r_state    <= S_FIN;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_dq * w_dl;
                    r_den   <= {r_a1[15], r_a1} - {r_a0[15], r_a0};
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_neg       <= r_prod[33];
                    r_div_dvd   <= r_prod[33] ? 32'(-r_prod) : r_prod[31:0];
                    r_state     <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_res_lift <= w_sat;
                        r_state    <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_lift   <= r_res_lift;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.status   = r_out_status;
    assign o_out.lift_out = r_out_lift;

`ifndef NO_ASSERTIONS
    a_lo_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEL) |-> $onehot0(w_lo_vec))
        else $error("more than one cell claims the lower segment end");

    a_seg_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEL && !w_below_min && !w_any_max && w_any_lo) |-> w_any_hi)
        else $error("lower segment end found without an upper end");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && w_div_done) |=> (r_state == S_FIN))
        else $error("divider result not taken");

    a_no_full_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_insert |-> !w_full)
        else $error("insert into a full table");
`endif

endmodule

FILE: src/stli_cell.sv
// ----------------------------------------------------------------------------
// stli_cell: one entry of the sorted table
// Holds one pair, shifts right on a sorted insert and flags its query role.
// ----------------------------------------------------------------------------
module stli_cell
    import stli_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  logic                     i_insert,
    input  logic signed [AngleW-1:0] i_key,
    input  logic signed [LiftW-1:0]  i_lift,
    input  t_fwd                     i_left,
    input  t_bwd                     i_right,
    output t_fwd                     o_fwd,
    output t_bwd                     o_bwd,
    output t_tap                     o_tap
);

    logic                     r_valid;
    logic signed [AngleW-1:0] r_angle;
    logic signed [LiftW-1:0]  r_lift;
    logic                     w_gt;
    logic                     w_below;
    logic                     w_eq;

    assign w_gt    = r_valid && (r_angle > i_key);
    assign w_below = r_valid && (i_key > r_angle);
    assign w_eq    = r_valid && (r_angle == i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= 1'b0;
        end else if (i_insert) begin
            // Larger entries move one place right; the new pair lands in the gap.
            if (i_left.gt) begin
                r_valid <= 1'b1;
                r_angle <= i_left.angle;
                r_lift  <= i_left.lift;
            end else if (i_left.valid && (w_gt || !r_valid)) begin
                r_valid <= 1'b1;
                r_angle <= i_key;
                r_lift  <= i_lift;
            end
        end
    end

    assign o_fwd = '{valid: r_valid, gt: w_gt, below: w_below,
                     angle: r_angle, lift: r_lift};
    assign o_bwd = '{valid: r_valid, below: w_below, eq: w_eq};

    assign o_tap = '{lo_hit:  w_below && !i_right.below,
                     hi_hit:  r_valid && i_left.below && !w_below,
                     ex_hit:  w_eq && !i_right.eq,
                     max_hit: w_below && !i_right.valid,
                     angle:   r_angle,
                     lift:    r_lift};

endmodule

FILE: src/stli_divider.sv
// ----------------------------------------------------------------------------
// stli_divider: serial unsigned divider
// Restoring division of a 32-bit magnitude by a 17-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module stli_divider
    import stli_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [16:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [31:0] r_dvd;
    logic [16:0] r_rem;
    logic [16:0] r_div;
    logic        r_done;
    logic [17:0] w_trial;
    logic [17:0] w_diff;
    logic        w_fit;

    assign w_trial = {r_rem, r_dvd[31]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                // The dividend register fills with quotient bits from the bottom.
                r_rem <= w_fit ? w_diff[16:0] : w_trial[16:0];
                r_dvd <= {r_dvd[30:0], w_fit};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule
